// ----- hw/rtl/cfir_pkg.sv -----
// ----------------------------------------------------------------------------
// cfir_pkg
// shared types and constants for the complex fir filter core
// ----------------------------------------------------------------------------
package cfir_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 17;
    localparam int INDEX_W    = 7;
    localparam int HALF_W     = 6;
    localparam int FRAC_BITS  = 15;
    localparam int MAX_TAPS_D = 65;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;

    localparam logic [HALF_W-1:0] HALF_LENGTH_RST = 6'd32;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] q;
        logic signed [SAMPLE_W-1:0] i;
    } sample_t;

    typedef struct packed {
        logic shift;
        logic rotate;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/cfir_cell.sv -----
// ----------------------------------------------------------------------------
// cfir_cell
// one tap cell: holds one history sample and one coefficient
// ----------------------------------------------------------------------------
module cfir_cell
    import cfir_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic                     load,
    input  logic signed [COEF_W-1:0] load_coef,
    input  sample_t                  prev_sample,
    input  sample_t                  next_sample,
    input  logic signed [COEF_W-1:0] next_coef,
    output sample_t                  sample,
    output logic signed [COEF_W-1:0] coef
);

    sample_t                  sample_reg;
    sample_t                  sample_next;
    logic signed [COEF_W-1:0] coef_reg;
    logic signed [COEF_W-1:0] coef_next;

    always_comb
    begin
        sample_next = sample_reg;
        coef_next   = coef_reg;
        if (ctrl.shift)
        begin
            sample_next = prev_sample;
        end
        else if (ctrl.rotate)
        begin
            sample_next = next_sample;
            coef_next   = next_coef;
        end
        if (load)
        begin
            coef_next = load_coef;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    // coefficients are undefined until loaded
    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign sample = sample_reg;
    assign coef   = coef_reg;

endmodule

// ----- hw/rtl/cfir_mac.sv -----
// ----------------------------------------------------------------------------
// cfir_mac
// head-of-chain multiply-accumulate with rounding and saturation
// ----------------------------------------------------------------------------
module cfir_mac
    import cfir_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_D
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       step,
    input  logic signed [COEF_W-1:0]   coef,
    input  sample_t                    sample,
    output logic signed [SAMPLE_W-1:0] res_i,
    output logic signed [SAMPLE_W-1:0] res_q,
    output logic                       clip
);

    localparam int PROD_W = COEF_W + SAMPLE_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS);
    localparam int RND_W  = ACC_W + 1;
    localparam int SH_W   = RND_W - FRAC_BITS;

    localparam logic signed [SH_W-1:0] POS_MAX = SH_W'(32767);
    localparam logic signed [SH_W-1:0] NEG_MIN = -SH_W'(32768);
    localparam logic signed [RND_W-1:0] HALF   = RND_W'(1) <<< (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] prod_i_reg;
    logic signed [PROD_W-1:0] prod_q_reg;
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_i_reg;
    logic signed [ACC_W-1:0]  acc_q_reg;
    logic signed [ACC_W-1:0]  acc_i_next;
    logic signed [ACC_W-1:0]  acc_q_next;

    logic signed [RND_W-1:0]  rnd_i;
    logic signed [RND_W-1:0]  rnd_q;
    logic signed [SH_W-1:0]   sh_i;
    logic signed [SH_W-1:0]   sh_q;
    logic                     clip_i;
    logic                     clip_q;

    always_ff @(posedge clk)
    begin
        prod_i_reg <= coef * sample.i;
        prod_q_reg <= coef * sample.q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= step;
        end
    end

    always_comb
    begin
        acc_i_next = acc_i_reg;
        acc_q_next = acc_q_reg;
        if (clear)
        begin
            acc_i_next = '0;
            acc_q_next = '0;
        end
        else if (prod_vld_reg)
        begin
            acc_i_next = acc_i_reg + ACC_W'(prod_i_reg);
            acc_q_next = acc_q_reg + ACC_W'(prod_q_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        acc_i_reg <= acc_i_next;
        acc_q_reg <= acc_q_next;
    end

    // round half up, shift toward minus infinity, saturate
    always_comb
    begin
        rnd_i  = RND_W'(acc_i_reg) + HALF;
        rnd_q  = RND_W'(acc_q_reg) + HALF;
        sh_i   = SH_W'(rnd_i >>> FRAC_BITS);
        sh_q   = SH_W'(rnd_q >>> FRAC_BITS);
        clip_i = (sh_i > POS_MAX) || (sh_i < NEG_MIN);
        clip_q = (sh_q > POS_MAX) || (sh_q < NEG_MIN);
        if (sh_i > POS_MAX)
            res_i = 16'sh7fff;
        else if (sh_i < NEG_MIN)
            res_i = -16'sh8000;
        else
            res_i = SAMPLE_W'(sh_i);
        if (sh_q > POS_MAX)
            res_q = 16'sh7fff;
        else if (sh_q < NEG_MIN)
            res_q = -16'sh8000;
        else
            res_q = SAMPLE_W'(sh_q);
        clip = clip_i | clip_q;
    end

endmodule

// ----- hw/rtl/complex_fir_filter_core.sv -----
// ----------------------------------------------------------------------------
// complex_fir_filter_core
// complex i/q fir filter for pulse shaping, built as a rotating chain of cells
// ----------------------------------------------------------------------------
// usage:
//   input stream s_*: each word either loads one real q2.15 coefficient
//   (s_tuser = 1) or filters one complex sample (s_tuser = 0).
//   output stream m_*: one word per filtered sample, nothing for a load.
//   cfg_we / cfg_wdata write half_length; active taps = 2*half_length+1,
//   capped at MAX_TAPS. write it only while the block is idle.
// sequence:
//   a load writes its cell on accept and the block stays idle. a sample
//   is shifted into the chain on accept, then the chain rotates all
//   MAX_TAPS cells once past the single multiplier at its head, the flush
//   state drains the product register and the done state rounds into the
//   output register. a new sample is accepted only in the idle state,
//   after the previous result has been loaded into the output register.
// reset:
//   history clears to zero, half_length returns to 32, coefficients stay
//   undefined until loaded.
// stall:
//   the output register holds its word while m_tready is low; the next
//   sample may already be accepted and finishes once the slot is free.
// ----------------------------------------------------------------------------
module complex_fir_filter_core
    import cfir_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_D
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sample_i[15:0], sample_q[31:16], coeff_index[38:32], coeff_value[55:39]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation[0]
    input  logic                  s_tuser,
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_i[15:0], out_q[31:16]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // saturated[0]
    output logic                  m_tuser,
    // configuration
    input  logic                  cfg_we,
    input  logic [HALF_W-1:0]     cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_TAPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_TAPS - 1);

    // input word fields
    sample_t                     in_sample;
    logic [INDEX_W-1:0]          in_index;
    logic signed [COEF_W-1:0]    in_coef;
    logic                        in_accept;
    logic                        in_is_load;

    assign in_sample.i = s_tdata[15:0];
    assign in_sample.q = s_tdata[31:16];
    assign in_index    = s_tdata[38:32];
    assign in_coef     = s_tdata[55:39];
    assign in_accept   = s_tvalid & s_tready;
    assign in_is_load  = (s_tuser == OP_LOAD);

    // control state
    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [HALF_W-1:0]   half_length_reg;
    logic [HALF_W-1:0]   half_length_next;
    logic                out_vld_reg;
    logic                out_vld_next;
    logic [SAMPLE_W-1:0] out_i_reg;
    logic [SAMPLE_W-1:0] out_q_reg;
    logic                out_sat_reg;

    // decoded controls
    cell_ctrl_t          ctrl;
    logic                acc_clear;
    logic                mac_step;
    logic                out_load;
    logic                out_free;
    logic [7:0]          tap_limit;

    // chain taps
    sample_t                  cell_sample [MAX_TAPS];
    logic signed [COEF_W-1:0] cell_coef   [MAX_TAPS];

    logic signed [SAMPLE_W-1:0] res_i;
    logic signed [SAMPLE_W-1:0] res_q;
    logic                       res_clip;

    // count of active taps, the cap at MAX_TAPS is implied since cnt < MAX_TAPS
    assign tap_limit = {1'b0, half_length_reg, 1'b1};
    assign out_free  = ~out_vld_reg | m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && !in_is_load)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FLUSH;
                    cnt_next   = '0;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready    = 1'b0;
        ctrl.shift  = 1'b0;
        ctrl.rotate = 1'b0;
        acc_clear   = 1'b0;
        mac_step    = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                ctrl.shift = s_tvalid & ~in_is_load;
                acc_clear  = s_tvalid & ~in_is_load;
            end
            ST_RUN:
            begin
                ctrl.rotate = 1'b1;
                mac_step    = (16'(cnt_reg) < 16'(tap_limit));
            end
            ST_FLUSH:
            begin
            end
            ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        half_length_next = half_length_reg;
        if (cfg_we)
            half_length_next = cfg_wdata;
        out_vld_next = out_vld_reg;
        if (out_load)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            half_length_reg <= HALF_LENGTH_RST;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            half_length_reg <= half_length_next;
            out_vld_reg     <= out_vld_next;
        end
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_i_reg   <= res_i;
            out_q_reg   <= res_q;
            out_sat_reg <= res_clip;
        end
    end

    // chain of tap cells: shift brings in a new sample at cell 0,
    // rotate moves every cell one place toward cell 0 with wrap
    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        localparam int NXT = (k + 1) % MAX_TAPS;
        sample_t prev_s;
        logic    load_k;

        if (k == 0)
        begin : g_head
            assign prev_s = in_sample;
        end
        else
        begin : g_body
            assign prev_s = cell_sample[k-1];
        end

        // loads beyond the chain match no cell and are dropped
        assign load_k = in_accept & in_is_load & (16'(in_index) == 16'(k));

        cfir_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .load        (load_k),
            .load_coef   (in_coef),
            .prev_sample (prev_s),
            .next_sample (cell_sample[NXT]),
            .next_coef   (cell_coef[NXT]),
            .sample      (cell_sample[k]),
            .coef        (cell_coef[k])
        );
    end

    // multiply-accumulate at the head of the chain
    cfir_mac #(
        .MAX_TAPS (MAX_TAPS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (acc_clear),
        .step   (mac_step),
        .coef   (cell_coef[0]),
        .sample (cell_sample[0]),
        .res_i  (res_i),
        .res_q  (res_q),
        .clip   (res_clip)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_q_reg, out_i_reg};
    assign m_tuser  = out_sat_reg;

endmodule
